>>> rtl/ugli_pkg.sv
// package for the uniform grid table interpolation unit: types and constants
`default_nettype none
package ugli_pkg;

  localparam int VAL_W  = 32;
  localparam int PC_W   = 11;
  localparam int FRAC_W = 16;
  localparam int CFG_W  = 2;
  localparam int IDX_W  = 10;

  localparam logic [FRAC_W:0] FRAC_ONE = 17'h10000;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_EVAL  = 1'b1
  } op_t;

  typedef enum logic [CFG_W-1:0] {
    CFG_GRID_LOW    = 2'd0,
    CFG_GRID_HIGH   = 2'd1,
    CFG_POINT_COUNT = 2'd2,
    CFG_GRID_SCALE  = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_IDX,
    ST_RD,
    ST_MAC,
    ST_FIN
  } state_t;

endpackage
`default_nettype wire

>>> rtl/ugli_ram.sv
// generic single write port, single read port ram with registered read data
`default_nettype none
module ugli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/uniform_grid_lut_linear_interp_unit.sv
// top level of the uniform grid table linear interpolation unit
`default_nettype none
// A write request (opcode 0) stores entry_value at entry_index; indexes at
// or beyond MAX_POINTS are dropped and give no result. An evaluate request
// (opcode 1) is answered with one result strobe on done; a position outside
// the grid range goes from idle straight to the final state. busy stays high
// from the accepting edge until the result is registered, so the next
// request can be taken in the same cycle in which done is shown. An
// evaluate inside the range makes one pass through a sequencer: the scale
// multiply, one read of the table (held as two copies so that both neighbor
// points come out in the same cycle), the difference, the fraction multiply
// and the final add. done is a single cycle strobe and cannot be held off.
// Table entries read before they were written give undefined results.
// Configuration must be written through cfg_valid/cfg_ready only while the
// unit is idle; the block itself does not enforce this.
module uniform_grid_lut_linear_interp_unit #(
  parameter int MAX_POINTS = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output      logic                          busy,
  input  wire logic                          opcode,
  input  wire logic [ugli_pkg::IDX_W-1:0]    entry_index,
  input  wire logic signed [ugli_pkg::VAL_W-1:0] entry_value,
  input  wire logic signed [ugli_pkg::VAL_W-1:0] position,
  output      logic                          done,
  output      logic signed [ugli_pkg::VAL_W-1:0] density_value,
  output      logic                          in_range,
  input  wire logic                          cfg_valid,
  output      logic                          cfg_ready,
  input  wire logic [ugli_pkg::CFG_W-1:0]    cfg_index,
  input  wire logic [ugli_pkg::VAL_W-1:0]    cfg_data
);

  localparam int AW  = $clog2(MAX_POINTS);
  localparam int NW  = ($clog2(MAX_POINTS + 1) > ugli_pkg::PC_W) ?
                       $clog2(MAX_POINTS + 1) : ugli_pkg::PC_W;
  localparam int CW  = (NW > ugli_pkg::FRAC_W) ? NW : ugli_pkg::FRAC_W;
  localparam int VW  = ugli_pkg::VAL_W;
  localparam int FW  = ugli_pkg::FRAC_W;
  localparam int EW  = (NW > ugli_pkg::IDX_W) ? NW : ugli_pkg::IDX_W;

  ugli_pkg::state_t state, state_next;

  logic signed [VW-1:0] grid_low;
  logic signed [VW-1:0] grid_high;
  logic [ugli_pkg::PC_W-1:0] point_count;
  logic [VW-1:0] grid_scale;

  logic accept;
  logic eval_req;
  logic wr_en;
  logic [AW-1:0] wr_addr;
  logic signed [VW:0] offset_full;
  logic pos_in;

  logic [VW-1:0] offset;
  logic rng;
  logic [2*VW-1:0] prod;
  logic [FW:0] frac;
  logic signed [VW-1:0] vi;
  logic signed [VW:0] diff;
  logic signed [FW+VW+1:0] mac;

  logic [VW-1:0] u;
  logic [NW-1:0] n_eff;
  logic [CW-1:0] idx_raw;
  logic [CW-1:0] idx_lim;
  logic clamped;
  logic [CW-1:0] idx_sel;
  logic [AW-1:0] rd_lo;
  logic [AW-1:0] rd_hi;
  logic [VW-1:0] ram_lo;
  logic [VW-1:0] ram_hi;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign eval_req  = accept && (opcode == ugli_pkg::OP_EVAL);
  assign wr_addr   = AW'(entry_index);
  assign wr_en     = accept && (opcode == ugli_pkg::OP_WRITE) &&
                     (EW'(entry_index) < EW'(MAX_POINTS));

  assign offset_full = {position[VW-1], position} - {grid_low[VW-1], grid_low};
  assign pos_in      = (position >= grid_low) && (position <= grid_high);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_low    <= '0;
      grid_high   <= VW'(32'h0001_0000);
      point_count <= ugli_pkg::PC_W'(2);
      grid_scale  <= VW'(32'h0001_0000);
    end else if (cfg_valid && cfg_ready) begin
      unique case (ugli_pkg::cfg_reg_t'(cfg_index))
        ugli_pkg::CFG_GRID_LOW:    grid_low    <= cfg_data;
        ugli_pkg::CFG_GRID_HIGH:   grid_high   <= cfg_data;
        ugli_pkg::CFG_POINT_COUNT: point_count <= cfg_data[ugli_pkg::PC_W-1:0];
        ugli_pkg::CFG_GRID_SCALE:  grid_scale  <= cfg_data;
        default: ;
      endcase
    end
  end

  // two table copies so both neighbor points are read in the same cycle
  ugli_ram #(.WIDTH(VW), .DEPTH(MAX_POINTS)) u_ram_lo (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (entry_value),
    .raddr (rd_lo),
    .rdata (ram_lo)
  );

  ugli_ram #(.WIDTH(VW), .DEPTH(MAX_POINTS)) u_ram_hi (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (entry_value),
    .raddr (rd_hi),
    .rdata (ram_hi)
  );

  // index and fraction from the scaled distance
  always_comb begin
    u = (prod[2*VW-1:VW+FW] != '0) ? '1 : prod[VW+FW-1:FW];
    if (NW'(point_count) < NW'(2)) begin
      n_eff = NW'(2);
    end else if (NW'(point_count) > NW'(MAX_POINTS)) begin
      n_eff = NW'(MAX_POINTS);
    end else begin
      n_eff = NW'(point_count);
    end
    idx_raw = CW'(u[VW-1:FW]);
    idx_lim = CW'(n_eff - NW'(2));
    clamped = idx_raw > idx_lim;
    idx_sel = clamped ? idx_lim : idx_raw;
    rd_lo   = idx_sel[AW-1:0];
    rd_hi   = rd_lo + AW'(1);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ugli_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ugli_pkg::ST_IDLE: begin
        if (eval_req) begin
          state_next = pos_in ? ugli_pkg::ST_MUL : ugli_pkg::ST_FIN;
        end
      end
      ugli_pkg::ST_MUL: state_next = ugli_pkg::ST_IDX;
      ugli_pkg::ST_IDX: state_next = ugli_pkg::ST_RD;
      ugli_pkg::ST_RD:  state_next = ugli_pkg::ST_MAC;
      ugli_pkg::ST_MAC: state_next = ugli_pkg::ST_FIN;
      ugli_pkg::ST_FIN: state_next = ugli_pkg::ST_IDLE;
      default:          state_next = ugli_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    unique case (state)
      ugli_pkg::ST_IDLE: busy = 1'b0;
      default:           busy = 1'b1;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    if (eval_req) begin
      offset <= offset_full[VW-1:0];
      rng    <= pos_in;
    end
    if (state == ugli_pkg::ST_MUL) begin
      prod <= {{VW{1'b0}}, offset} * {{VW{1'b0}}, grid_scale};
    end
    if (state == ugli_pkg::ST_IDX) begin
      frac <= clamped ? ugli_pkg::FRAC_ONE : {1'b0, u[FW-1:0]};
    end
    if (state == ugli_pkg::ST_RD) begin
      vi   <= ram_lo;
      diff <= $signed({ram_hi[VW-1], ram_hi}) - $signed({ram_lo[VW-1], ram_lo});
    end
    if (state == ugli_pkg::ST_MAC) begin
      mac <= $signed({{(VW+1){1'b0}}, frac}) * $signed({{(FW+1){diff[VW]}}, diff});
    end
    if (state == ugli_pkg::ST_FIN) begin
      density_value <= rng ? (vi + mac[FW+VW-1:FW]) : '0;
      in_range      <= rng;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == ugli_pkg::ST_FIN);
    end
  end

  a_done_after_fin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ugli_pkg::ST_FIN))
    else $error("result strobe without a finished evaluation");

  a_out_of_range_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !in_range) |-> (density_value == '0))
    else $error("out of range result is not zero");

  a_eval_goes_busy: assert property (@(posedge clk) disable iff (rst)
    eval_req |=> busy)
    else $error("evaluate request did not start the sequencer");

  a_read_index_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ugli_pkg::ST_IDX) |-> (idx_sel < CW'(MAX_POINTS - 1)))
    else $error("table read index beyond last interval");

endmodule
`default_nettype wire

>>> bench/tb_top.sv
// testbench for the uniform grid table linear interpolation unit
`timescale 1ns / 1ps
module tb_top;
  import ugli_pkg::*;

  localparam int MAX_POINTS  = 1024;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE      = 8;

  typedef struct packed {
    logic [VAL_W-1:0] density;
    logic             in_range;
  } density_result_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  logic                    opcode = OP_WRITE;
  logic [IDX_W-1:0]        entry_index = '0;
  logic signed [VAL_W-1:0] entry_value = '0;
  logic signed [VAL_W-1:0] position = '0;
  logic                    done;
  logic signed [VAL_W-1:0] density_value;
  logic                    in_range;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_W-1:0]        cfg_index = CFG_GRID_LOW;
  logic [VAL_W-1:0]        cfg_data = '0;

  // local copy of the block state
  logic signed [VAL_W-1:0] grid_low_q = 32'sd0;
  logic signed [VAL_W-1:0] grid_high_q = 32'sd65536;
  logic [PC_W-1:0]         point_count_q = 11'd2;
  logic [VAL_W-1:0]        grid_scale_q = 32'd65536;
  logic signed [VAL_W-1:0] table_image [MAX_POINTS];
  bit                      entry_loaded [MAX_POINTS];

  density_result_t pending_results [$];
  int failure_count = 0;
  int cycle_count = 0;
  int gap_ceiling = 0;

  uniform_grid_lut_linear_interp_unit #(.MAX_POINTS(MAX_POINTS)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode),
    .entry_index(entry_index), .entry_value(entry_value), .position(position),
    .done(done), .density_value(density_value), .in_range(in_range),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic report_failure(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    failure_count++;
  endtask

  function automatic void locate_cell(input logic signed [VAL_W-1:0] pos,
                                      output int unsigned slot,
                                      output longint unsigned frac, output bit hit);
    longint x, lo, hi;
    longint unsigned d, u, n, idx;
    x = pos;
    lo = grid_low_q;
    hi = grid_high_q;
    hit = (x >= lo) && (x <= hi);
    slot = 0;
    frac = 0;
    if (hit) begin
      n = point_count_q;
      if (n < 2) n = 2;
      if (n > MAX_POINTS) n = MAX_POINTS;
      d = x - lo;
      u = (d * grid_scale_q) >> FRAC_W;
      if (u > 64'hFFFF_FFFF) u = 64'hFFFF_FFFF;
      idx = u >> FRAC_W;
      if (idx > n - 2) idx = n - 2;
      frac = u - (idx << FRAC_W);
      if (frac > FRAC_ONE) frac = FRAC_ONE;
      slot = 32'(idx);
    end
  endfunction

  function automatic density_result_t predict_density(input logic signed [VAL_W-1:0] pos);
    int unsigned slot;
    longint unsigned frac;
    bit hit;
    longint vi, vj, fs, s;
    density_result_t r;
    locate_cell(pos, slot, frac, hit);
    r.density = '0;
    r.in_range = hit;
    if (hit) begin
      vi = table_image[slot];
      vj = table_image[slot + 1];
      fs = frac;
      s = (65536 - fs) * vi + fs * vj;
      r.density = 32'(s >>> FRAC_W);
    end
    return r;
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return 32'($signed($urandom) >>> 12);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] pick_position();
    longint lo, hi;
    longint unsigned span;
    lo = grid_low_q;
    hi = grid_high_q;
    span = 0;
    case ($urandom_range(0, 11))
      0: return grid_low_q;
      1: return grid_high_q;
      2: return grid_low_q - 1;
      3: return grid_high_q + 1;
      4, 5: return $urandom;
      default: begin
        if (hi < lo) return $urandom;
        span = hi - lo + 1;
        return 32'(lo + longint'({$urandom, $urandom} % span));
      end
    endcase
  endfunction

  task automatic send_request(input op_t op, input logic [IDX_W-1:0] idx,
                              input logic [VAL_W-1:0] val, input logic [VAL_W-1:0] pos);
    int gap;
    gap = $urandom_range(0, gap_ceiling);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    opcode <= op;
    entry_index <= idx;
    entry_value <= val;
    position <= pos;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (op == OP_WRITE) begin
      table_image[idx] = val;
      entry_loaded[idx] = 1'b1;
    end else begin
      pending_results.push_back(predict_density(pos));
    end
  endtask

  // load both neighbor points first so no unwritten entry is ever read
  task automatic evaluate_at(input logic [VAL_W-1:0] pos);
    int unsigned slot;
    longint unsigned frac;
    bit hit;
    locate_cell(pos, slot, frac, hit);
    if (hit && !entry_loaded[slot])
      send_request(OP_WRITE, IDX_W'(slot), pick_value(), $urandom);
    if (hit && !entry_loaded[slot + 1])
      send_request(OP_WRITE, IDX_W'(slot + 1), pick_value(), $urandom);
    send_request(OP_EVAL, IDX_W'($urandom), $urandom, pos);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_grid(input logic [VAL_W-1:0] lo, input logic [VAL_W-1:0] hi,
                          input logic [PC_W-1:0] n, input logic [VAL_W-1:0] scale);
    logic [VAL_W-1:0] vals [4];
    cfg_reg_t r;
    vals = '{lo, hi, 32'(n), scale};
    wait_drained();
    for (int k = 0; k < 4; k++) begin
      r = cfg_reg_t'(k);
      cfg_valid <= 1'b1;
      cfg_index <= r;
      cfg_data <= vals[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (r)
        CFG_GRID_LOW:    grid_low_q = vals[k];
        CFG_GRID_HIGH:   grid_high_q = vals[k];
        CFG_POINT_COUNT: point_count_q = vals[k][PC_W-1:0];
        CFG_GRID_SCALE:  grid_scale_q = vals[k];
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic test_default_grid();
    logic [VAL_W-1:0] probes [9] = '{32'h0, 32'h0001_0000, 32'h0000_8000, 32'h1,
                                     32'h0000_FFFF, 32'hFFFF_FFFF, 32'h0001_0001,
                                     32'h8000_0000, 32'h7FFF_FFFF};
    gap_ceiling = 0;
    send_request(OP_WRITE, 10'd0, 32'h7FFF_FFFF, $urandom);
    send_request(OP_WRITE, 10'd1, 32'h8000_0000, $urandom);
    foreach (probes[k]) evaluate_at(probes[k]);
  endtask

  task automatic test_saturation();
    gap_ceiling = 13;
    set_grid(32'h8000_0000, 32'h7FFF_FFFF, 11'd1024, 32'hFFFF_FFFF);
    evaluate_at(32'h8000_0000);
    evaluate_at(32'h8000_0001);
    evaluate_at(32'h0);
    evaluate_at(32'h7FFF_FFFF);
  endtask

  task automatic test_count_clamp();
    gap_ceiling = 13;
    set_grid(32'h0, 32'h0004_0000, 11'd0, 32'h0001_0000);
    evaluate_at(32'h0003_0000);
    evaluate_at(32'h0000_4000);
    set_grid(32'h0, 32'h0004_0000, 11'd1, 32'h0);
    evaluate_at(32'h0002_0000);
    set_grid(32'hFFFF_0000, 32'h7FFF_FFFF, 11'd2047, 32'h0001_0000);
    evaluate_at(32'h0002_8000);
    evaluate_at(32'h7FFF_FFFF);
  endtask

  task automatic test_inverted_range();
    gap_ceiling = 13;
    set_grid(32'h0001_0000, 32'hFFFF_0000, 11'd8, 32'h0001_0000);
    evaluate_at(32'h0);
    evaluate_at(32'h0001_0000);
    evaluate_at(32'hFFFF_0000);
  endtask

  task automatic test_random_traffic();
    longint lo, hi, w;
    longint unsigned n, n_eff, scale;
    logic [VAL_W-1:0] tmp;
    for (int p = 0; p < 10; p++) begin
      lo = longint'($signed($urandom)) >>> $urandom_range(0, 24);
      w = longint'($urandom >> $urandom_range(0, 28)) + 1;
      hi = lo + w;
      if (hi > 64'sd2147483647) hi = 64'sd2147483647;
      case ($urandom_range(0, 9))
        0: n = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(1025, 2047);
        1, 2: n = $urandom_range(17, 1024);
        default: n = $urandom_range(2, 16);
      endcase
      n_eff = (n < 2) ? 2 : (n > MAX_POINTS) ? MAX_POINTS : n;
      scale = ((n_eff - 1) << 32) / longint'(hi - lo);
      if (scale > 64'hFFFF_FFFF) scale = 64'hFFFF_FFFF;
      case ($urandom_range(0, 9))
        0: scale = 0;
        1, 2: scale = $urandom;
        default: ;
      endcase
      if ($urandom_range(0, 9) == 0) begin
        tmp = lo;
        lo = hi;
        hi = $signed(tmp);
      end
      set_grid(32'(lo), 32'(hi), PC_W'(n), 32'(scale));
      gap_ceiling = ($urandom_range(0, 2) == 0) ? 0 : 13;
      for (int k = 0; k < 160; k++) begin
        if ($urandom_range(0, 59) == 0) wait_drained();
        if ($urandom_range(0, 3) == 0)
          send_request(OP_WRITE, IDX_W'($urandom), pick_value(), $urandom);
        else
          evaluate_at(pick_position());
      end
    end
  endtask

  always @(posedge clk) begin : result_check
    density_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_failure("result strobe with no request outstanding");
      end else begin
        want = pending_results.pop_front();
        if (in_range !== want.in_range)
          report_failure($sformatf("in_range got %b want %b", in_range, want.in_range));
        if (density_value !== want.density)
          report_failure($sformatf("density_value got %h want %h",
                                   density_value, want.density));
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_default_grid();
    test_saturation();
    test_count_clamp();
    test_inverted_range();
    test_random_traffic();
    wait_drained();
    if (failure_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
